### rtl/bhpq_pkg.sv
// bhpq_pkg: shared types, codes and default sizes for the binary heap priority queue
// no dependencies; imported by bhpq_cmp, bhpq_ctrl and the top level
package bhpq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int KEY_PORT_W = 32;
  localparam int TOTAL_W    = 7;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS = 2'd1;

  typedef struct packed {
    logic min_first;
    logic signed_keys;
  } bhpq_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_WB,
    ST_POP_LAST,
    ST_DN_CMP,
    ST_FIN
  } bhpq_state_t;

endpackage

### rtl/bhpq_ram.sv
// bhpq_ram: generic synchronous ram, one write port, two registered read ports
// no dependencies
module bhpq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata0,
  output logic [WIDTH-1:0]  rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/bhpq_cmp.sv
// bhpq_cmp: strict priority compare of two keys, max or min order, signed or unsigned
// depends on bhpq_pkg
module bhpq_cmp import bhpq_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  bhpq_cfg_t            cfg,
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  output logic                 above
);

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] fa;
  logic [KEY_WIDTH-1:0] fb;

  always_comb begin
    flip = '0;
    flip[KEY_WIDTH-1] = cfg.signed_keys;
    fa = a ^ flip;
    fb = b ^ flip;
    above = cfg.min_first ? (fa < fb) : (fa > fb);
  end

endmodule

### rtl/bhpq_ctrl.sv
// bhpq_ctrl: request sequencer, sift-up and sift-down over the heap ram
// depends on bhpq_pkg and bhpq_cmp; drives the ram ports of the top level
module bhpq_ctrl import bhpq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int ADDR_W    = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bhpq_cfg_t             cfg,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [KEY_PORT_W-1:0] out_removed_key,
  output logic                  out_top_valid,
  output logic [KEY_PORT_W-1:0] out_top_key,
  output logic [TOTAL_W-1:0]    out_entry_total,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [KEY_WIDTH-1:0]  mem_wdata,
  output logic [ADDR_W-1:0]     mem_raddr0,
  output logic [ADDR_W-1:0]     mem_raddr1,
  input  logic [KEY_WIDTH-1:0]  mem_rdata0,
  input  logic [KEY_WIDTH-1:0]  mem_rdata1
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = ADDR_W + 2;

  bhpq_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] v_r, v_nxt;
  logic [KEY_WIDTH-1:0] top_r, top_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [KEY_WIDTH-1:0] removed_r, removed_nxt;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [KEY_WIDTH+KEY_PORT_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_par;
  logic [ADDR_W-1:0]    up_pos;
  logic [ADDR_W-1:0]    up_up;
  logic [IW-1:0]        l_idx;
  logic [IW-1:0]        r_idx;
  logic [IW-1:0]        n_ext;
  logic                 l_in;
  logic                 r_in;
  logic                 up_mv;
  logic                 r_above_l;
  logic                 l_above_v;
  logic                 r_above_v;
  logic                 pick_r;
  logic                 pick_mv;
  logic [ADDR_W-1:0]    pick_idx;
  logic [KEY_WIDTH-1:0] pick_d;
  logic [IW-1:0]        pc_l;
  logic [IW-1:0]        pc_r;
  logic [KEY_WIDTH+KEY_PORT_W-1:0] top_ext;
  logic [KEY_WIDTH+KEY_PORT_W-1:0] rem_ext;
  logic [CW+TOTAL_W-1:0] tot_ext;

  bhpq_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp_up (
    .cfg(cfg), .a(v_r), .b(mem_rdata0), .above(up_mv)
  );
  bhpq_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp_rl (
    .cfg(cfg), .a(mem_rdata1), .b(mem_rdata0), .above(r_above_l)
  );
  bhpq_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp_lv (
    .cfg(cfg), .a(mem_rdata0), .b(v_r), .above(l_above_v)
  );
  bhpq_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp_rv (
    .cfg(cfg), .a(mem_rdata1), .b(v_r), .above(r_above_v)
  );

  assign busy   = !(state_r inside {ST_IDLE, ST_FIN});
  assign accept = start && !busy;
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);

  always_comb begin
    key_ext  = {{KEY_WIDTH{1'b0}}, in_key};
    key_in   = key_ext[KEY_WIDTH-1:0];
    cnt_m1   = count_r - CW'(1);
    cnt_par  = cnt_m1 >> 1;
    up_pos   = (pos_r - ADDR_W'(1)) >> 1;
    up_up    = (up_pos - ADDR_W'(1)) >> 1;
    l_idx    = {1'b0, pos_r, 1'b1};
    r_idx    = l_idx + IW'(1);
    n_ext    = IW'(count_r);
    l_in     = (l_idx < n_ext);
    r_in     = (r_idx < n_ext);
    pick_r   = r_in && r_above_l;
    pick_idx = pick_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
    pick_d   = pick_r ? mem_rdata1 : mem_rdata0;
    pick_mv  = pick_r ? r_above_v : l_above_v;
    pc_l     = {1'b0, pick_idx, 1'b1};
    pc_r     = pc_l + IW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_FIN: begin
        if (accept) begin
          case (in_req_type)
            REQ_PUSH: begin
              if (full) begin
                state_nxt = ST_FIN;
              end else if (empty) begin
                state_nxt = ST_WB;
              end else begin
                state_nxt = ST_UP_CMP;
              end
            end
            REQ_POP: begin
              state_nxt = empty ? ST_FIN : ST_POP_LAST;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP_CMP: begin
        if (up_mv) begin
          state_nxt = (up_pos == '0) ? ST_WB : ST_UP_CMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_WB: begin
        state_nxt = ST_FIN;
      end
      ST_POP_LAST: begin
        state_nxt = empty ? ST_FIN : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_nxt = (l_in && pick_mv) ? ST_DN_CMP : ST_FIN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = v_r;
    mem_raddr0  = pc_l[ADDR_W-1:0];
    mem_raddr1  = pc_r[ADDR_W-1:0];
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    v_nxt       = v_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    case (state_r)
      ST_IDLE, ST_FIN: begin
        if (accept) begin
          status_nxt  = STAT_DONE;
          removed_nxt = '0;
          case (in_req_type)
            REQ_PUSH: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                v_nxt      = key_in;
                pos_nxt    = count_r[ADDR_W-1:0];
                count_nxt  = count_r + CW'(1);
                mem_raddr0 = cnt_par[ADDR_W-1:0];
              end
            end
            REQ_POP: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                removed_nxt = top_r;
                count_nxt   = cnt_m1;
                mem_raddr0  = cnt_m1[ADDR_W-1:0];
              end
            end
            default: begin
              status_nxt = STAT_DONE;
            end
          endcase
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (up_mv) begin
          mem_wdata  = mem_rdata0;
          pos_nxt    = up_pos;
          mem_raddr0 = up_up;
        end
      end
      ST_WB: begin
        mem_we = 1'b1;
      end
      ST_POP_LAST: begin
        v_nxt      = mem_rdata0;
        pos_nxt    = '0;
        mem_raddr0 = ADDR_W'(1);
        mem_raddr1 = ADDR_W'(2);
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (l_in && pick_mv) begin
          mem_wdata = pick_d;
          pos_nxt   = pick_idx;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    top_nxt = (mem_we && mem_waddr == '0) ? mem_wdata : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    v_r       <= v_nxt;
    top_r     <= top_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  always_comb begin
    top_ext         = {{KEY_PORT_W{1'b0}}, top_r};
    rem_ext         = {{KEY_PORT_W{1'b0}}, removed_r};
    tot_ext         = {{TOTAL_W{1'b0}}, count_r};
    out_valid       = (state_r == ST_FIN);
    out_status      = status_r;
    out_removed_key = rem_ext[KEY_PORT_W-1:0];
    out_top_valid   = !empty;
    out_top_key     = empty ? '0 : top_ext[KEY_PORT_W-1:0];
    out_entry_total = tot_ext[TOTAL_W-1:0];
  end

endmodule

### rtl/binary_heap_priority_queue.sv
// binary_heap_priority_queue: top level, config registers, heap ram and sequencer
// depends on bhpq_pkg, bhpq_ram, bhpq_cmp, bhpq_ctrl
// a peek or failed request goes straight from the accepted start to out_valid; push and pop first
// sift through the heap, one ram read per sift level
// a new start is taken in the cycle that shows the result; the receiver cannot stall
// rst_n (synchronous) empties the heap and clears both config registers; no clearing pass
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [KEY_PORT_W-1:0] out_removed_key,
  output logic                  out_top_valid,
  output logic [KEY_PORT_W-1:0] out_top_key,
  output logic [TOTAL_W-1:0]    out_entry_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data
);

  localparam int ADDR_W = $clog2(CAPACITY);

  bhpq_cfg_t cfg_r, cfg_nxt;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr0;
  logic [ADDR_W-1:0]    mem_raddr1;
  logic [KEY_WIDTH-1:0] mem_rdata0;
  logic [KEY_WIDTH-1:0] mem_rdata1;

  assign cfg_ready = 1'b1;

  // config beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_FIRST:   cfg_nxt.min_first   = cfg_data;
        CFG_SIGNED_KEYS: cfg_nxt.signed_keys = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr0(mem_raddr0),
    .raddr1(mem_raddr1),
    .rdata0(mem_rdata0),
    .rdata1(mem_rdata1)
  );

  bhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_removed_key(out_removed_key),
    .out_top_valid  (out_top_valid),
    .out_top_key    (out_top_key),
    .out_entry_total(out_entry_total),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr0     (mem_raddr0),
    .mem_raddr1     (mem_raddr1),
    .mem_rdata0     (mem_rdata0),
    .mem_rdata1     (mem_rdata1)
  );

endmodule
